/* sv/obd2_response_decoder_tracker_assert.svh */
// Assertion macros used by the checker of this block.
`ifndef OBD2_RESPONSE_DECODER_TRACKER_ASSERT_SVH
`define OBD2_RESPONSE_DECODER_TRACKER_ASSERT_SVH

// Same-cycle implication, sampled on clk, ignored while rst_expr is high.
`define OBD2_ASSERT_IMPLY(lbl, rst_expr, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst_expr) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, ignored while rst_expr is high.
`define OBD2_ASSERT_NEXT(lbl, rst_expr, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst_expr) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/obd2rdt_pkg.sv */
`default_nettype none

package obd2rdt_pkg;

  // Port widths
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 168;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 16;

  // Item kind on in_tuser
  localparam logic FUNC_FRAME = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  localparam logic [7:0] SVC_MODE01_REPLY = 8'h41;

  localparam logic [7:0] PID_COOLANT      = 8'h05;
  localparam logic [7:0] PID_RPM          = 8'h0C;
  localparam logic [7:0] PID_SPEED        = 8'h0D;
  localparam logic [7:0] PID_RUN_TIME     = 8'h1F;
  localparam logic [7:0] PID_FUEL         = 8'h2F;
  localparam logic [7:0] PID_DIST_CLEARED = 8'h31;
  localparam logic [7:0] PID_ODOMETER     = 8'hA6;

  localparam logic [8:0]  COOLANT_OFFSET = 9'd40;
  localparam logic [31:0] TIME_UNSET     = 32'hFFFF_FFFF;

  // ceil(2^35 / 9): exact floor(z/9) for any 31-bit z
  localparam logic [31:0] RECIP_9     = 32'd3817748708;
  localparam int          RECIP_SHIFT = 35;

  // Config register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_RPM_STOP  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_RESP_TMO  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_STOP_HOLD = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_SPEED_GAP = 2'd3;

  localparam logic [13:0] RPM_STOP_RST  = 14'd300;
  localparam logic [15:0] RESP_TMO_RST  = 16'd30000;
  localparam logic [15:0] STOP_HOLD_RST = 16'd5000;
  localparam logic [15:0] SPEED_GAP_RST = 16'd5000;

  typedef struct packed {
    logic        func;
    logic [31:0] now_ms;
    logic [7:0]  service_byte;
    logic [7:0]  pid_byte;
    logic [7:0]  data_a;
    logic [7:0]  data_b;
    logic [7:0]  data_c;
    logic [7:0]  data_d;
  } item_t;

  typedef struct packed {
    logic [13:0] rpm_stop_threshold;
    logic [15:0] response_timeout_ms;
    logic [15:0] stop_hold_ms;
    logic [15:0] speed_gap_ms;
  } cfg_t;

  typedef struct packed {
    logic [8:0]  coolant_celsius;
    logic [13:0] engine_rpm;
    logic [7:0]  vehicle_kmh;
    logic [15:0] reported_run_seconds;
    logic [7:0]  fuel_raw;
    logic [31:0] odometer_raw;
    logic [15:0] distance_since_clear;
    logic [31:0] engine_run_ms;
  } vals_t;

  function automatic logic [31:0] min_u32(logic [31:0] a, logic [31:0] b);
    return (a < b) ? a : b;
  endfunction

  // floor(5*r/18) for a remainder r in 0..17
  function automatic logic [2:0] frac_of_18(logic [4:0] r);
    logic [2:0] f;
    unique case (r)
      5'd0, 5'd1, 5'd2, 5'd3:         f = 3'd0;
      5'd4, 5'd5, 5'd6, 5'd7:         f = 3'd1;
      5'd8, 5'd9, 5'd10:              f = 3'd2;
      5'd11, 5'd12, 5'd13, 5'd14:     f = 3'd3;
      5'd15, 5'd16, 5'd17:            f = 3'd4;
      default:                        f = 3'd0;
    endcase
    return f;
  endfunction

endpackage

`default_nettype wire

/* sv/obd2rdt_tracker.sv */
`default_nettype none

module obd2rdt_tracker
  import obd2rdt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        fire,     // apply item, load result stage
  input  wire item_t       item,
  input  wire cfg_t        cfg,
  output vals_t            vals,     // values after the last applied item
  output logic [31:0]      acc       // distance accumulator, mm*3.6
);

  logic [7:0]  coolant_r, coolant_nxt;
  logic [13:0] rpm_r, rpm_nxt;
  logic [7:0]  speed_r, speed_nxt;
  logic [15:0] run_s_r, run_s_nxt;
  logic [7:0]  fuel_r, fuel_nxt;
  logic [31:0] odo_r, odo_nxt;
  logic [15:0] dsc_r, dsc_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [31:0] last_spd_r, last_spd_nxt;
  logic [31:0] start_r, start_nxt;
  logic [31:0] stop_r, stop_nxt;
  logic [31:0] last_resp_r, last_resp_nxt;
  logic [31:0] run_ms_r, run_ms_nxt;

  logic [31:0] spd_gap;
  logic [31:0] resp_age;
  logic [31:0] stop_age;
  logic [23:0] step_dist;
  logic [13:0] rpm_new;

  assign spd_gap   = item.now_ms - last_spd_r;
  assign resp_age  = item.now_ms - last_resp_r;
  assign stop_age  = item.now_ms - stop_r;
  // gap is below a 16-bit limit whenever it is used
  assign step_dist = 24'(item.data_a) * 24'(spd_gap[15:0]);
  assign rpm_new   = {item.data_a, item.data_b[7:2]};

  always_comb begin
    coolant_nxt   = coolant_r;
    rpm_nxt       = rpm_r;
    speed_nxt     = speed_r;
    run_s_nxt     = run_s_r;
    fuel_nxt      = fuel_r;
    odo_nxt       = odo_r;
    dsc_nxt       = dsc_r;
    acc_nxt       = acc_r;
    last_spd_nxt  = last_spd_r;
    start_nxt     = start_r;
    stop_nxt      = stop_r;
    last_resp_nxt = last_resp_r;

    if (item.func == FUNC_FRAME) begin
      if (item.service_byte == SVC_MODE01_REPLY) begin
        last_resp_nxt = item.now_ms;
        unique case (item.pid_byte)
          PID_COOLANT: coolant_nxt = item.data_a;
          PID_SPEED: begin
            speed_nxt = item.data_a;
            if (last_spd_r != 32'd0 && spd_gap < {16'd0, cfg.speed_gap_ms}) begin
              acc_nxt = acc_r + {8'd0, step_dist};
            end
            last_spd_nxt = item.now_ms;
          end
          PID_RUN_TIME: run_s_nxt = {item.data_a, item.data_b};
          PID_FUEL:     fuel_nxt  = item.data_a;
          PID_ODOMETER: odo_nxt   = {item.data_a, item.data_b, item.data_c, item.data_d};
          PID_RPM: begin
            rpm_nxt = rpm_new;
            if (rpm_new < cfg.rpm_stop_threshold) begin
              stop_nxt = min_u32(item.now_ms, stop_r);
            end else begin
              start_nxt = min_u32(item.now_ms, start_r);
              stop_nxt  = TIME_UNSET;
            end
          end
          PID_DIST_CLEARED: dsc_nxt = {item.data_a, item.data_b};
          default: ;
        endcase
      end
    end else begin
      // timeout wins; stop hold only looks at a stop time that survived it
      if (resp_age > {16'd0, cfg.response_timeout_ms}) begin
        start_nxt   = TIME_UNSET;
        stop_nxt    = TIME_UNSET;
        rpm_nxt     = '0;
        speed_nxt   = '0;
        coolant_nxt = '0;
      end else if (stop_r != TIME_UNSET && stop_age > {16'd0, cfg.stop_hold_ms}) begin
        start_nxt = TIME_UNSET;
        stop_nxt  = TIME_UNSET;
      end
    end

    if (start_nxt == TIME_UNSET) begin
      run_ms_nxt = '0;
    end else begin
      run_ms_nxt = min_u32(item.now_ms, stop_nxt) - start_nxt + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coolant_r   <= '0;
      rpm_r       <= '0;
      speed_r     <= '0;
      run_s_r     <= '0;
      fuel_r      <= '0;
      odo_r       <= '0;
      dsc_r       <= '0;
      acc_r       <= '0;
      last_spd_r  <= '0;
      start_r     <= TIME_UNSET;
      stop_r      <= TIME_UNSET;
      last_resp_r <= '0;
    end else if (fire) begin
      coolant_r   <= coolant_nxt;
      rpm_r       <= rpm_nxt;
      speed_r     <= speed_nxt;
      run_s_r     <= run_s_nxt;
      fuel_r      <= fuel_nxt;
      odo_r       <= odo_nxt;
      dsc_r       <= dsc_nxt;
      acc_r       <= acc_nxt;
      last_spd_r  <= last_spd_nxt;
      start_r     <= start_nxt;
      stop_r      <= stop_nxt;
      last_resp_r <= last_resp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      run_ms_r <= run_ms_nxt;
    end
  end

  // state registers double as the result stage
  always_comb begin
    vals.coolant_celsius      = {1'b0, coolant_r} - COOLANT_OFFSET;
    vals.engine_rpm           = rpm_r;
    vals.vehicle_kmh          = speed_r;
    vals.reported_run_seconds = run_s_r;
    vals.fuel_raw             = fuel_r;
    vals.odometer_raw         = odo_r;
    vals.distance_since_clear = dsc_r;
    vals.engine_run_ms        = run_ms_r;
  end

  assign acc = acc_r;

endmodule

`default_nettype wire

/* sv/obd2rdt_mm_scale.sv */
`default_nettype none

module obd2rdt_mm_scale
  import obd2rdt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        ld_mul,
  input  wire logic        ld_out,
  input  wire logic [31:0] acc,
  output logic [30:0]      dist_mm
);

  // floor(acc*5/18) = 5*q + floor(5*r/18), q = acc/18, r = acc%18
  // stage 1: q = floor((acc>>1)/9) by reciprocal multiply
  logic [62:0] prod;
  logic [27:0] q_r;
  logic [4:0]  acc_lo_r;
  logic [4:0]  q18_lo;
  logic [4:0]  rem;
  logic [30:0] dist_r;

  assign prod = 63'(acc[31:1]) * 63'(RECIP_9);

  always_ff @(posedge clk) begin
    if (ld_mul) begin
      q_r      <= prod[62:RECIP_SHIFT];
      acc_lo_r <= acc[4:0];
    end
  end

  // stage 2: remainder from low bits only, then 5q + fraction
  assign q18_lo = 5'({q_r[0], 4'd0} + {q_r[3:0], 1'b0});
  assign rem    = acc_lo_r - q18_lo;

  always_ff @(posedge clk) begin
    if (ld_out) begin
      dist_r <= 31'({q_r, 2'd0}) + 31'(q_r) + 31'(frac_of_18(rem));
    end
  end

  assign dist_mm = dist_r;

endmodule

`default_nettype wire

/* sv/obd2_response_decoder_tracker.sv */
`default_nettype none

// OBD-II mode-01 reply decoder and engine/distance tracker. Each input beat is a
// received frame (in_tuser=0) or a time tick (in_tuser=1); every beat yields one
// output beat holding all decoded values, the engine run time and the integrated
// distance in mm. Throughput is one beat per clock while out_tready is high. A beat
// passes through the input register (loaded at the accept edge), the state
// update, then two stages for the acc*5/18 scaling (31x32 reciprocal
// multiply, then remainder fix-up). Output stalls back up through the stages,
// so up to four beats can be in flight. Config writes belong to idle time.
module obd2_response_decoder_tracker
  import obd2rdt_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // config write port
  input  wire logic                   cfg_we,
  input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
  // input beats
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // low to high: now_ms[31:0], service_byte, pid_byte, data_a, data_b,
  // data_c, data_d
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  input  wire logic                   in_tuser,   // func: 0 frame, 1 tick
  // result beats
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // low to high: coolant_celsius[8:0], engine_rpm[13:0], vehicle_kmh[7:0],
  // reported_run_seconds[15:0], fuel_raw[7:0], odometer_raw[31:0],
  // distance_since_clear[15:0], engine_run_ms[31:0], distance_mm[30:0], 2'b0
  output logic [OUT_TDATA_W-1:0]      out_tdata
);

  cfg_t  cfg_r;
  item_t item_r;
  vals_t trk_vals;
  vals_t vals2_r;
  vals_t vals3_r;
  logic [31:0] trk_acc;
  logic [30:0] dist_mm;

  logic v0_r, v1_r, v2_r, v3_r;
  logic en0, en1, en2, en3;

  // each stage moves when it is empty or the stage after it moves
  assign en3 = !v3_r || out_tready;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign en0 = !v0_r || en1;

  assign in_tready = en0;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rpm_stop_threshold  <= RPM_STOP_RST;
      cfg_r.response_timeout_ms <= RESP_TMO_RST;
      cfg_r.stop_hold_ms        <= STOP_HOLD_RST;
      cfg_r.speed_gap_ms        <= SPEED_GAP_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_RPM_STOP:  cfg_r.rpm_stop_threshold  <= cfg_wdata[13:0];
        CFG_RESP_TMO:  cfg_r.response_timeout_ms <= cfg_wdata;
        CFG_STOP_HOLD: cfg_r.stop_hold_ms        <= cfg_wdata;
        CFG_SPEED_GAP: cfg_r.speed_gap_ms        <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en0) v0_r <= in_tvalid;
      if (en1) v1_r <= v0_r;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  // input register: unpack beat
  always_ff @(posedge clk) begin
    if (en0 && in_tvalid) begin
      item_r.func         <= in_tuser;
      item_r.now_ms       <= in_tdata[31:0];
      item_r.service_byte <= in_tdata[39:32];
      item_r.pid_byte     <= in_tdata[47:40];
      item_r.data_a       <= in_tdata[55:48];
      item_r.data_b       <= in_tdata[63:56];
      item_r.data_c       <= in_tdata[71:64];
      item_r.data_d       <= in_tdata[79:72];
    end
  end

  // state update; its registers are the stage-1 result
  obd2rdt_tracker u_trk (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (v0_r && en1),
    .item  (item_r),
    .cfg   (cfg_r),
    .vals  (trk_vals),
    .acc   (trk_acc)
  );

  // distance scaling runs beside the value copies in stages 2 and 3
  obd2rdt_mm_scale u_scale (
    .clk     (clk),
    .ld_mul  (v1_r && en2),
    .ld_out  (v2_r && en3),
    .acc     (trk_acc),
    .dist_mm (dist_mm)
  );

  always_ff @(posedge clk) begin
    if (v1_r && en2) vals2_r <= trk_vals;
    if (v2_r && en3) vals3_r <= vals2_r;
  end

  assign out_tvalid = v3_r;
  assign out_tdata  = {2'b00,
                       dist_mm,
                       vals3_r.engine_run_ms,
                       vals3_r.distance_since_clear,
                       vals3_r.odometer_raw,
                       vals3_r.fuel_raw,
                       vals3_r.reported_run_seconds,
                       vals3_r.vehicle_kmh,
                       vals3_r.engine_rpm,
                       vals3_r.coolant_celsius};

endmodule

`default_nettype wire

/* sv/obd2rdt_checker.sv */
`default_nettype none

`include "obd2_response_decoder_tracker_assert.svh"

module obd2rdt_checker
  import obd2rdt_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata
);

  // a stalled result beat holds
  `OBD2_ASSERT_NEXT(a_out_hold, !rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result beat changed under stall")

  // reset empties the pipe
  `OBD2_ASSERT_NEXT(a_rst_empty, 1'b0, !rst_n, !out_tvalid, "result valid right after reset")

  // coolant never reads below -40
  `OBD2_ASSERT_IMPLY(a_coolant_rng, !rst_n, out_tvalid, !out_tdata[8] || out_tdata[8:0] >= 9'h1D8, "coolant below range")

  // with the sink ready throughout, an accepted beat shows up as a valid result beat
  `OBD2_ASSERT_NEXT(a_latency, !rst_n, in_tvalid && in_tready && out_tready ##1 out_tready ##1 out_tready ##1 out_tready, out_tvalid, "result beat missing")

endmodule

bind obd2_response_decoder_tracker obd2rdt_checker u_obd2rdt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

/* tb/sv/obd2_tracker_checker.sv */
module obd2_tracker_checker
  import obd2rdt_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                   in_tvalid,
  input  wire logic                   in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  input  wire logic                   in_tuser,
  input  wire logic                   out_tvalid,
  input  wire logic                   out_tready,
  input  wire logic [OUT_TDATA_W-1:0] out_tdata,
  output int                          mismatches,
  output int                          open_reports
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    vals_t       vals;
    logic [30:0] distance_mm;
  } report_t;

  // register copies
  logic [13:0] stop_rpm;
  logic [15:0] resp_tmo;
  logic [15:0] hold_ms;
  logic [15:0] gap_ms;

  // tracker state
  logic [7:0]  coolant_q;
  logic [13:0] rpm_q;
  logic [7:0]  speed_q;
  logic [15:0] run_s_q;
  logic [7:0]  fuel_q;
  logic [31:0] odo_q;
  logic [15:0] dist_clr_q;
  logic [31:0] acc_q;
  logic [31:0] last_speed;
  logic [31:0] start_t;
  logic [31:0] stop_t;
  logic [31:0] last_resp;

  report_t pending_reports [$];
  report_t want;
  report_t got;

  // Applies one beat to the tracker state and returns the report it yields.
  function automatic report_t next_report(logic func, logic [IN_TDATA_W-1:0] d);
    logic [31:0] now;
    logic [31:0] gap;
    logic [31:0] stop_or_now;
    logic [7:0]  svc;
    logic [7:0]  pid;
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  c;
    logic [7:0]  e;
    logic [15:0] ab;
    logic [39:0] prod;
    logic [35:0] scaled;
    report_t     r;
    now = d[31:0];
    svc = d[39:32];
    pid = d[47:40];
    a   = d[55:48];
    b   = d[63:56];
    c   = d[71:64];
    e   = d[79:72];
    ab  = {a, b};
    if (func == FUNC_FRAME) begin
      if (svc == SVC_MODE01_REPLY) begin
        last_resp = now;
        case (pid)
          PID_COOLANT: coolant_q = a;
          PID_SPEED: begin
            gap = now - last_speed;
            speed_q = a;
            if (last_speed != 32'd0 && gap < {16'd0, gap_ms}) begin
              prod  = 40'(a) * 40'(gap);
              acc_q = acc_q + prod[31:0];
            end
            last_speed = now;
          end
          PID_RUN_TIME:     run_s_q = ab;
          PID_FUEL:         fuel_q = a;
          PID_ODOMETER:     odo_q = {a, b, c, e};
          PID_DIST_CLEARED: dist_clr_q = ab;
          PID_RPM: begin
            rpm_q = ab[15:2];
            if (rpm_q < stop_rpm) begin
              stop_t = (now < stop_t) ? now : stop_t;
            end else begin
              start_t = (now < start_t) ? now : start_t;
              stop_t  = TIME_UNSET;
            end
          end
          default: ;
        endcase
      end
    end else begin
      // timeout first, then the stop hold
      gap = now - last_resp;
      if (gap > {16'd0, resp_tmo}) begin
        start_t   = TIME_UNSET;
        stop_t    = TIME_UNSET;
        rpm_q     = '0;
        speed_q   = '0;
        coolant_q = '0;
      end
      gap = now - stop_t;
      if (stop_t != TIME_UNSET && gap > {16'd0, hold_ms}) begin
        start_t = TIME_UNSET;
        stop_t  = TIME_UNSET;
      end
    end
    stop_or_now = (now < stop_t) ? now : stop_t;
    scaled = ({4'd0, acc_q} * 36'd5) / 36'd18;
    r.vals.coolant_celsius      = {1'b0, coolant_q} - COOLANT_OFFSET;
    r.vals.engine_rpm           = rpm_q;
    r.vals.vehicle_kmh          = speed_q;
    r.vals.reported_run_seconds = run_s_q;
    r.vals.fuel_raw             = fuel_q;
    r.vals.odometer_raw         = odo_q;
    r.vals.distance_since_clear = dist_clr_q;
    r.vals.engine_run_ms        = (start_t == TIME_UNSET) ? 32'd0
                                  : stop_or_now - start_t + 32'd1;
    r.distance_mm               = scaled[30:0];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] w, input logic [31:0] g);
    if (g !== w) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch in %s: expected %0h, got %0h", name, w, g);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      stop_rpm   = RPM_STOP_RST;
      resp_tmo   = RESP_TMO_RST;
      hold_ms    = STOP_HOLD_RST;
      gap_ms     = SPEED_GAP_RST;
      coolant_q  = '0;
      rpm_q      = '0;
      speed_q    = '0;
      run_s_q    = '0;
      fuel_q     = '0;
      odo_q      = '0;
      dist_clr_q = '0;
      acc_q      = '0;
      last_speed = '0;
      start_t    = TIME_UNSET;
      stop_t     = TIME_UNSET;
      last_resp  = '0;
      pending_reports.delete();
      open_reports <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_RPM_STOP:  stop_rpm = cfg_wdata[13:0];
          CFG_RESP_TMO:  resp_tmo = cfg_wdata;
          CFG_STOP_HOLD: hold_ms  = cfg_wdata;
          CFG_SPEED_GAP: gap_ms   = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        pending_reports.push_back(next_report(in_tuser, in_tdata));
      if (out_tvalid && out_tready) begin
        if (pending_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result beat with nothing expected: %0h", out_tdata);
        end else begin
          want = pending_reports.pop_front();
          {got.distance_mm, got.vals.engine_run_ms, got.vals.distance_since_clear,
           got.vals.odometer_raw, got.vals.fuel_raw, got.vals.reported_run_seconds,
           got.vals.vehicle_kmh, got.vals.engine_rpm, got.vals.coolant_celsius}
            = out_tdata[165:0];
          check_field("coolant_celsius", want.vals.coolant_celsius,
                      got.vals.coolant_celsius);
          check_field("engine_rpm", want.vals.engine_rpm, got.vals.engine_rpm);
          check_field("vehicle_kmh", want.vals.vehicle_kmh, got.vals.vehicle_kmh);
          check_field("reported_run_seconds", want.vals.reported_run_seconds,
                      got.vals.reported_run_seconds);
          check_field("fuel_raw", want.vals.fuel_raw, got.vals.fuel_raw);
          check_field("odometer_raw", want.vals.odometer_raw, got.vals.odometer_raw);
          check_field("distance_since_clear", want.vals.distance_since_clear,
                      got.vals.distance_since_clear);
          check_field("engine_run_ms", want.vals.engine_run_ms,
                      got.vals.engine_run_ms);
          check_field("distance_mm", want.distance_mm, got.distance_mm);
        end
      end
      open_reports <= pending_reports.size();
    end
  end

endmodule

/* tb/sv/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import obd2rdt_pkg::*;

  localparam int HOLD_CYCLES  = 300;     // long receiver hold-off
  localparam int DRAIN_CYCLES = 16;      // settle time after the last report
  localparam int CYCLE_LIMIT  = 200000;  // watchdog

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_ADDR_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0]  cfg_wdata;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  int                     mismatches;
  int                     open_reports;

  // Stimulus-side copy of the registers, used only to aim time steps and
  // engine speeds at the block's thresholds.
  logic [13:0] sh_rpm;
  logic [15:0] sh_tmo;
  logic [15:0] sh_hold;
  logic [15:0] sh_gap;
  logic [31:0] t_now;   // running millisecond clock fed to the block

  // Idle control: quiet_* turn off random idling on one side, hold_req asks
  // the receiver for one long hold-off, hold_done says it is over.
  bit quiet_in;
  bit quiet_out;
  bit hold_req;
  bit hold_done;

  logic [7:0] known_pids [0:6] = '{PID_COOLANT, PID_RPM, PID_SPEED, PID_RUN_TIME,
                                   PID_FUEL, PID_DIST_CLEARED, PID_ODOMETER};

  obd2_response_decoder_tracker DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  obd2_tracker_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .mismatches   (mismatches),
    .open_reports (open_reports)
  );

  // 10 ns clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("** obd2_response_decoder_tracker: FAILED **");
    $finish;
  end

  // Receiver: random back-pressure, a quiet stretch on request, and one long
  // hold-off counted here so the pipeline fills and in_tready drops.
  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        out_tready <= quiet_out || ($urandom_range(99) >= 34);
        @(posedge clk);
      end
    end
  end

  // One input beat, preceded by a random number of idle cycles. Returns at
  // the edge where the beat was taken, so back-to-back beats keep tvalid high.
  task automatic send(input logic func, input logic [31:0] now, input logic [7:0] svc,
                      input logic [7:0] pid, input logic [7:0] a, input logic [7:0] b,
                      input logic [7:0] c, input logic [7:0] d);
    int idle_n;
    idle_n = 0;
    if (!quiet_in)
      while ($urandom_range(99) < 34) idle_n++;
    if (idle_n > 0) begin
      in_tvalid <= 1'b0;
      repeat (idle_n) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {d, c, b, a, pid, svc, now};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Stop offering beats until every expected report has come back.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (open_reports != 0);
  endtask

  // Write all four registers back to back; only called with the block idle.
  task automatic set_config(input logic [13:0] rpm, input logic [15:0] tmo,
                            input logic [15:0] hold, input logic [15:0] gap);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_RPM_STOP;
    cfg_wdata <= {2'b00, rpm};
    @(posedge clk);
    cfg_addr  <= CFG_RESP_TMO;
    cfg_wdata <= tmo;
    @(posedge clk);
    cfg_addr  <= CFG_STOP_HOLD;
    cfg_wdata <= hold;
    @(posedge clk);
    cfg_addr  <= CFG_SPEED_GAP;
    cfg_wdata <= gap;
    @(posedge clk);
    cfg_we  <= 1'b0;
    sh_rpm  = rpm;
    sh_tmo  = tmo;
    sh_hold = hold;
    sh_gap  = gap;
  endtask

  // One random beat. In highway mode nearly every beat is a fast speed
  // reply at a gap close to the widest that still integrates, to drive the distance
  // accumulator through its wrap.
  task automatic rand_item(input bit highway);
    int          sel;
    int          step_sel;
    logic        func;
    logic [7:0]  svc;
    logic [7:0]  pid;
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  c;
    logic [7:0]  d;
    logic [16:0] rpm_raw;
    func = FUNC_FRAME;
    svc  = SVC_MODE01_REPLY;
    a    = 8'($urandom);
    b    = 8'($urandom);
    c    = 8'($urandom);
    d    = 8'($urandom);
    sel  = $urandom_range(99);
    if (highway && sel < 95) begin
      pid   = PID_SPEED;
      a     = 8'($urandom_range(240, 255));
      t_now = t_now + $urandom_range(60000, 65534);
    end else begin
      // time step: mostly short, often right at a threshold, now and then a
      // jump anywhere in the 32-bit range (wrap included)
      step_sel = $urandom_range(11);
      if (step_sel <= 5)
        t_now = t_now + $urandom_range(1500);
      else if (step_sel == 6)
        t_now = t_now + {16'd0, sh_gap} + $urandom_range(2) - 1;
      else if (step_sel == 7)
        t_now = t_now + {16'd0, sh_tmo} + $urandom_range(2) - 1;
      else if (step_sel == 8)
        t_now = t_now + {16'd0, sh_hold} + $urandom_range(2) - 1;
      else if (step_sel == 9)
        t_now = t_now + $urandom_range(70000);
      else if (step_sel == 10)
        t_now = $urandom;
      // step_sel 11: same millisecond again

      if (sel < 25) begin
        func = FUNC_TICK;           // frame fields left random
        svc  = 8'($urandom);
        pid  = 8'($urandom);
      end else if (sel < 32) begin
        svc = 8'($urandom);         // mostly some other service
        pid = known_pids[$urandom_range(6)];
      end else if (sel < 38) begin
        pid = 8'($urandom);         // mostly an unknown PID
      end else begin
        sel = $urandom_range(9);
        if (sel <= 6)      pid = known_pids[sel];
        else if (sel <= 8) pid = PID_SPEED;
        else               pid = PID_RPM;
      end
      // half the engine speed replies land right around the stop threshold
      if (pid == PID_RPM && $urandom_range(1) == 1) begin
        rpm_raw = 17'({1'b0, sh_rpm, 2'b00} + $urandom_range(8) - 4);
        {a, b}  = rpm_raw[15:0];
      end
    end
    send(func, t_now, svc, pid, a, b, c, d);
  endtask

  initial begin
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_addr  <= '0;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tuser  <= FUNC_FRAME;
    in_tdata  <= '0;
    quiet_in  = 1'b0;
    quiet_out = 1'b0;
    hold_req  = 1'b0;
    hold_done = 1'b0;
    sh_rpm    = RPM_STOP_RST;
    sh_tmo    = RESP_TMO_RST;
    sh_hold   = STOP_HOLD_RST;
    sh_gap    = SPEED_GAP_RST;
    t_now     = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part, reset register values ----
    // coolant reads -40 right after reset
    send(FUNC_TICK, 32'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    // not a mode-01 reply: ignored entirely
    send(FUNC_FRAME, 32'd50, 8'h40, PID_COOLANT, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    // mode-01 reply, unknown PID: only the response time moves
    send(FUNC_FRAME, 32'd100, SVC_MODE01_REPLY, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    // coolant extremes, unused payload bytes set
    send(FUNC_FRAME, 32'd150, SVC_MODE01_REPLY, PID_COOLANT, 8'hFF, 8'hAA, 8'h55, 8'hFF);
    send(FUNC_FRAME, 32'd200, SVC_MODE01_REPLY, PID_COOLANT, 8'h00, 8'h00, 8'h00, 8'h00);
    // top engine speed: engine starts
    send(FUNC_FRAME, 32'd300, SVC_MODE01_REPLY, PID_RPM, 8'hFF, 8'hFF, 8'h00, 8'h00);
    // first speed sample (last sample time 0) does not integrate
    send(FUNC_FRAME, 32'd1000, SVC_MODE01_REPLY, PID_SPEED, 8'hFF, 8'h00, 8'h00, 8'h00);
    send(FUNC_FRAME, 32'd2000, SVC_MODE01_REPLY, PID_SPEED, 8'hFF, 8'h00, 8'h00, 8'h00);
    // gap one below the limit integrates, gap at the limit does not
    send(FUNC_FRAME, 32'd6999, SVC_MODE01_REPLY, PID_SPEED, 8'h80, 8'h00, 8'h00, 8'h00);
    send(FUNC_FRAME, 32'd11999, SVC_MODE01_REPLY, PID_SPEED, 8'h80, 8'h00, 8'h00, 8'h00);
    // one-, two- and four-byte PIDs at full scale
    send(FUNC_FRAME, 32'd12000, SVC_MODE01_REPLY, PID_RUN_TIME, 8'hFF, 8'hFF, 8'h00, 8'h00);
    send(FUNC_FRAME, 32'd12001, SVC_MODE01_REPLY, PID_FUEL, 8'hFF, 8'h00, 8'h00, 8'h00);
    send(FUNC_FRAME, 32'd12002, SVC_MODE01_REPLY, PID_ODOMETER, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send(FUNC_FRAME, 32'd12003, SVC_MODE01_REPLY, PID_DIST_CLEARED,
         8'hFF, 8'hFF, 8'h00, 8'h00);
    // byte order of the odometer
    send(FUNC_FRAME, 32'd12004, SVC_MODE01_REPLY, PID_ODOMETER, 8'h01, 8'h02, 8'h03, 8'h04);
    // engine stops; hold time reached exactly, then exceeded
    send(FUNC_FRAME, 32'd12010, SVC_MODE01_REPLY, PID_RPM, 8'h00, 8'h00, 8'h00, 8'h00);
    send(FUNC_TICK, 32'd17010, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send(FUNC_TICK, 32'd17011, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    // engine speed equal to the threshold counts as running
    send(FUNC_FRAME, 32'd20000, SVC_MODE01_REPLY, PID_RPM, 8'h04, 8'hB0, 8'h00, 8'h00);
    // silence equal to the timeout keeps values, one more ms clears them
    send(FUNC_TICK, 32'd50000, 8'h41, PID_RPM, 8'h00, 8'h00, 8'h00, 8'h00);
    send(FUNC_TICK, 32'd50001, 8'h41, PID_RPM, 8'h00, 8'h00, 8'h00, 8'h00);
    // speed samples across the 32-bit time wrap
    send(FUNC_FRAME, 32'hFFFF_FF00, SVC_MODE01_REPLY, PID_SPEED,
         8'h10, 8'h00, 8'h00, 8'h00);
    send(FUNC_FRAME, 32'h0000_0100, SVC_MODE01_REPLY, PID_SPEED,
         8'hFF, 8'h00, 8'h00, 8'h00);
    // engine starts just before the wrap; run time wraps with it
    send(FUNC_FRAME, 32'hFFFF_FFF0, SVC_MODE01_REPLY, PID_RPM, 8'hFF, 8'hFF, 8'h00, 8'h00);
    send(FUNC_FRAME, 32'h0000_0005, SVC_MODE01_REPLY, PID_COOLANT,
         8'h80, 8'h00, 8'h00, 8'h00);
    t_now = 32'd5;

    // ---- all registers at their low end ----
    set_config(14'd0, 16'd0, 16'd0, 16'd0);
    repeat (120) rand_item(1'b0);

    // ---- all registers at their high end; long speed run wraps the
    // accumulator ----
    set_config(14'h3FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    repeat (300) rand_item(1'b1);

    // ---- short timeouts, with the pressure tests ----
    set_config(14'd300, 16'd3000, 16'd1500, 16'd2500);
    for (int i = 0; i < 200; i++) begin
      if (i == 40)
        hold_req = 1'b1;          // receiver holds off, sender keeps offering
      if (i == 100)
        wait_idle();              // sender pauses until all reports are back
      if (i == 120) begin
        quiet_in  = 1'b1;         // full-rate stretch on both sides
        quiet_out = 1'b1;
      end
      if (i == 180) begin
        quiet_in  = 1'b0;
        quiet_out = 1'b0;
      end
      rand_item(1'b0);
    end

    // ---- random register values ----
    set_config(14'($urandom_range(1000)), 16'($urandom_range(20000)),
               16'($urandom_range(8000)), 16'($urandom_range(8000)));
    repeat (200) rand_item(1'b0);

    // drain, then give any stray beat time to show up
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && open_reports == 0) begin
      $display("** obd2_response_decoder_tracker: PASSED **");
    end else begin
      $display("** obd2_response_decoder_tracker: FAILED **");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+sv
sv/obd2rdt_pkg.sv
sv/obd2rdt_tracker.sv
sv/obd2rdt_mm_scale.sv
sv/obd2_response_decoder_tracker.sv
sv/obd2rdt_checker.sv
tb/sv/obd2_tracker_checker.sv
tb/sv/tb.sv
